// File: hdl/mlcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the memory LCD line sender.
// No dependencies; every file of the block but mlcd_frame_ram imports this package.
package mlcd_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_UPDATE     = 3'd0;
  localparam logic [2:0] REG_VCOM_MASK  = 3'd1;
  localparam logic [2:0] REG_ALL_CLEAR  = 3'd2;
  localparam logic [2:0] REG_INVERSION  = 3'd3;
  localparam logic [2:0] REG_NO_UPDATE  = 3'd4;
  localparam logic [2:0] REG_BACKGROUND = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_UPDATE     = 8'h90;
  localparam logic [7:0] RST_VCOM_MASK  = 8'h40;
  localparam logic [7:0] RST_ALL_CLEAR  = 8'h20;
  localparam logic [7:0] RST_INVERSION  = 8'h14;
  localparam logic [7:0] RST_NO_UPDATE  = 8'h00;
  localparam logic [3:0] RST_BACKGROUND = 4'h0;

  // Frame store word filled in by the clearing pass (two bytes, four nibbles)
  localparam logic [15:0] FILL_WORD = {4{RST_BACKGROUND}};

  // Item modes
  localparam logic [1:0] MODE_DRAW   = 2'd0;
  localparam logic [1:0] MODE_LINE   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_INVERT = 2'd3;

  // Output queue geometry
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PW    = 2;
  localparam int OUT_CW    = 3;

  typedef struct packed {
    logic [7:0] update_command;
    logic [7:0] vcom_mask;
    logic [7:0] all_clear_command;
    logic [7:0] inversion_command;
    logic [7:0] no_update_command;
    logic [3:0] background_colour;
  } cfg_t;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } beat_t;

endpackage

// File: hdl/mlcd_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style register file holding the command bytes and background colour.
// Depends on mlcd_pkg for register indexes, reset values and cfg_t.
module mlcd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlcd_pkg::CFG_AW-1:0]  paddr,
  input  logic [mlcd_pkg::CFG_DW-1:0]  pwdata,
  output logic [mlcd_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output mlcd_pkg::cfg_t               cfg
);
  import mlcd_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Write a register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_command    <= RST_UPDATE;
      cfg_r.vcom_mask         <= RST_VCOM_MASK;
      cfg_r.all_clear_command <= RST_ALL_CLEAR;
      cfg_r.inversion_command <= RST_INVERSION;
      cfg_r.no_update_command <= RST_NO_UPDATE;
      cfg_r.background_colour <= RST_BACKGROUND;
    end else if (wr_en) begin
      case (reg_idx)
        REG_UPDATE:     cfg_r.update_command    <= pwdata[7:0];
        REG_VCOM_MASK:  cfg_r.vcom_mask         <= pwdata[7:0];
        REG_ALL_CLEAR:  cfg_r.all_clear_command <= pwdata[7:0];
        REG_INVERSION:  cfg_r.inversion_command <= pwdata[7:0];
        REG_NO_UPDATE:  cfg_r.no_update_command <= pwdata[7:0];
        REG_BACKGROUND: cfg_r.background_colour <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_UPDATE:     prdata = CFG_DW'(cfg_r.update_command);
      REG_VCOM_MASK:  prdata = CFG_DW'(cfg_r.vcom_mask);
      REG_ALL_CLEAR:  prdata = CFG_DW'(cfg_r.all_clear_command);
      REG_INVERSION:  prdata = CFG_DW'(cfg_r.inversion_command);
      REG_NO_UPDATE:  prdata = CFG_DW'(cfg_r.no_update_command);
      REG_BACKGROUND: prdata = CFG_DW'(cfg_r.background_colour);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hdl/mlcd_frame_ram.sv
`timescale 1ns / 1ps
// Frame store: one 16-bit word per pair of row bytes, one write port and one
// read port with registered read data. Uses no package items.
module mlcd_frame_ram #(
  parameter int DEPTH = 7744,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  assign rdata = rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: hdl/mlcd_out_fifo.sv
`timescale 1ns / 1ps
// Small output queue between the sequencer and the result channel.
// Depends on mlcd_pkg for beat_t and the queue geometry.
module mlcd_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  mlcd_pkg::beat_t             push_beat,
  output logic [mlcd_pkg::OUT_CW-1:0] count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_word,
  output logic                        out_last
);
  import mlcd_pkg::*;

  beat_t              q_r [OUT_DEPTH];
  logic [OUT_PW-1:0]  wr_ptr_r;
  logic [OUT_PW-1:0]  rd_ptr_r;
  logic [OUT_CW-1:0]  count_r;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_word  = q_r[rd_ptr_r].word;
  assign out_last  = q_r[rd_ptr_r].last;
  assign count     = count_r;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_beat;
    end
  end

  // Never write into a full queue without a pop; never read an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != OUT_CW'(OUT_DEPTH)) || pop)
    else $error("output queue overflow");

endmodule

// File: hdl/mlcd_seq.sv
`timescale 1ns / 1ps
// Sequencer: clearing pass, nibble read-modify-write for draws, and word
// framing for line and command transfers. Depends on mlcd_pkg.
module mlcd_seq #(
  parameter int PANEL_WIDTH  = 176,
  parameter int PANEL_HEIGHT = 176,
  parameter int DEPTH        = 7744,
  parameter int AW           = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mlcd_pkg::cfg_t              cfg,
  // item channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [8:0]                  in_column,
  input  logic [8:0]                  in_row,
  input  logic [3:0]                  in_colour,
  input  logic                        in_flag,
  // frame store
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [15:0]                 ram_wdata,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [15:0]                 ram_rdata,
  // output queue
  input  logic [mlcd_pkg::OUT_CW-1:0] fifo_count,
  output logic                        push,
  output mlcd_pkg::beat_t             push_beat
);
  import mlcd_pkg::*;

  localparam int ROW_BYTES = (PANEL_WIDTH + 1) / 2;
  localparam int PAIRS     = (ROW_BYTES + 1) / 2;
  localparam int BW        = $clog2(PAIRS + 2);
  localparam logic [8:0]    WIDTH9    = 9'(PANEL_WIDTH);
  localparam logic [8:0]    HEIGHT9   = 9'(PANEL_HEIGHT);
  localparam logic [BW-1:0] BEAT_LAST = BW'(PAIRS + 1);
  localparam logic [BW-1:0] BEAT_DATA = BW'(PAIRS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DECODE  = 3'd2;
  localparam logic [2:0] S_DRAW_RD = 3'd3;
  localparam logic [2:0] S_DRAW_WR = 3'd4;
  localparam logic [2:0] S_LINE    = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [BW-1:0] beat_r, beat_nxt;
  logic          vcom_r, vcom_nxt;
  logic          slot_valid_r, slot_valid_nxt;
  logic          slot_mem_r, slot_mem_nxt;
  logic [15:0]   slot_word_r, slot_word_nxt;
  logic          slot_last_r, slot_last_nxt;

  logic [1:0]    item_mode_r;
  logic [8:0]    item_col_r;
  logic [8:0]    item_row_r;
  logic [3:0]    item_colour_r;
  logic          item_flag_r;

  logic          accept;
  logic          credit;
  logic [7:0]    vcom_bits;
  logic [7:0]    cmd_byte;
  logic [7:0]    line_byte;
  logic [AW-1:0] row_base;
  logic          in_panel;
  logic [15:0]   draw_word;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign vcom_bits = vcom_r ? cfg.vcom_mask : 8'h00;
  assign line_byte = item_row_r[7:0] + 8'd1;
  assign row_base  = AW'(item_row_r[7:0]) * AW'(PAIRS);
  assign in_panel  = (item_col_r < WIDTH9) && (item_row_r < HEIGHT9);

  // One more word may enter the pipe if the queue still has room for it
  assign credit = ({1'b0, fifo_count} + {{OUT_CW{1'b0}}, slot_valid_r})
                  < (OUT_CW + 1)'(OUT_DEPTH);

  // Command byte for clear and invert items
  always_comb begin
    case (item_mode_r)
      MODE_CLEAR:  cmd_byte = item_flag_r ? cfg.all_clear_command
                                          : cfg.no_update_command;
      MODE_INVERT: cmd_byte = item_flag_r ? cfg.inversion_command
                                          : cfg.no_update_command;
      default:     cmd_byte = cfg.no_update_command;
    endcase
  end

  // Replace one nibble; even columns sit in the high nibble of each byte
  always_comb begin
    draw_word = ram_rdata;
    case (item_col_r[1:0])
      2'd0:    draw_word[15:12] = item_colour_r;
      2'd1:    draw_word[11:8]  = item_colour_r;
      2'd2:    draw_word[7:4]   = item_colour_r;
      default: draw_word[3:0]   = item_colour_r;
    endcase
  end

  // Drive the next state
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    clr_addr_nxt   = clr_addr_r;
    beat_nxt       = beat_r;
    vcom_nxt       = vcom_r;
    slot_valid_nxt = 1'b0;
    slot_mem_nxt   = 1'b0;
    slot_word_nxt  = slot_word_r;
    slot_last_nxt  = slot_last_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = draw_word;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = FILL_WORD;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (item_mode_r)
          MODE_DRAW: begin
            if (in_panel) begin
              addr_nxt  = row_base + AW'(item_col_r[8:2]);
              state_nxt = S_DRAW_RD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          MODE_LINE: begin
            if (item_row_r < HEIGHT9) begin
              addr_nxt  = row_base;
              beat_nxt  = '0;
              state_nxt = S_LINE;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (credit) begin
              slot_valid_nxt = 1'b1;
              slot_word_nxt  = {cmd_byte | vcom_bits, 8'h00};
              slot_last_nxt  = 1'b1;
              vcom_nxt       = !vcom_r;
              state_nxt      = S_IDLE;
            end
          end
        endcase
      end

      S_DRAW_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_DRAW_WR;
      end

      S_DRAW_WR: begin
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end

      S_LINE: begin
        if (credit) begin
          slot_valid_nxt = 1'b1;
          beat_nxt       = beat_r + 1'b1;
          if (beat_r == '0) begin
            // header: command with polarity, then 1-based line number
            slot_word_nxt = {cfg.update_command | vcom_bits, line_byte};
            slot_last_nxt = 1'b0;
            vcom_nxt      = !vcom_r;
          end else if (beat_r == BEAT_LAST) begin
            // trailer: two zero bytes (for an odd row the first one sits in
            // the last data word's low byte, which only the fill ever writes)
            slot_word_nxt = 16'h0000;
            slot_last_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ram_re        = 1'b1;
            slot_mem_nxt  = 1'b1;
            slot_last_nxt = 1'b0;
            addr_nxt      = addr_r + 1'b1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      vcom_r       <= 1'b1;
      slot_valid_r <= 1'b0;
      beat_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      vcom_r       <= vcom_nxt;
      slot_valid_r <= slot_valid_nxt;
      beat_r       <= beat_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    slot_mem_r  <= slot_mem_nxt;
    slot_word_r <= slot_word_nxt;
    slot_last_r <= slot_last_nxt;
    if (accept) begin
      item_mode_r   <= in_mode;
      item_col_r    <= in_column;
      item_row_r    <= in_row;
      item_colour_r <= in_colour;
      item_flag_r   <= in_flag;
    end
  end

  // Hand the word to the queue; memory words arrive in the cycle after the read
  assign push           = slot_valid_r;
  assign push_beat.word = slot_mem_r ? ram_rdata : slot_word_r;
  assign push_beat.last = slot_last_r;

  // A word enters the pipe only when the queue can take it
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    slot_valid_r |-> (fifo_count != OUT_CW'(OUT_DEPTH)))
    else $error("word pushed without queue room");

  // Polarity flips only together with a header or command word
  a_vcom: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && !$stable(vcom_r)) |-> (slot_valid_r && !slot_mem_r))
    else $error("vcom toggled without a command word");

  // A draw never reads and writes the store in the same cycle
  a_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame store read and write overlap");

  // Line beat counter stays inside the transfer
  a_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINE) |-> (beat_r <= BEAT_LAST) && (beat_r > BEAT_DATA ||
                             beat_r <= BEAT_DATA))
    else $error("line beat counter out of range");

endmodule

// File: hdl/memory_lcd_frame_line_sender_core.sv
`timescale 1ns / 1ps
// Top level of the memory LCD frame store and line sender.
// Depends on mlcd_pkg, mlcd_cfg_regs, mlcd_frame_ram, mlcd_out_fifo, mlcd_seq.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  in_      | input     | in_valid/in_stall  | mode, column, row, colour, flag
//  out_     | output    | out_valid/out_stall| word (16 bits), last
//  apb      | input     | psel/penable/pready| paddr, pwdata, prdata (6 registers)
//
// After reset a clearing pass writes every frame store word, PANEL_HEIGHT *
// ceil(ceil(PANEL_WIDTH/2)/2) words (7744 at 176 x 176); items stall until then.
// A line item sends a header word, the row's data words and a trailer word: the
// single frame store read port yields one word per cycle while the queue has room.
// A draw reads, modifies and writes back one word; clear or invert sends one word.
// A 4-word output queue lets the next item start while results wait under out_stall.
module memory_lcd_frame_line_sender_core #(
  parameter int PANEL_WIDTH  = 176,
  parameter int PANEL_HEIGHT = 176
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [8:0]                  in_column,
  input  logic [8:0]                  in_row,
  input  logic [3:0]                  in_colour,
  input  logic                        in_flag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_word,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlcd_pkg::CFG_AW-1:0] paddr,
  input  logic [mlcd_pkg::CFG_DW-1:0] pwdata,
  output logic [mlcd_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import mlcd_pkg::*;

  localparam int ROW_BYTES = (PANEL_WIDTH + 1) / 2;
  localparam int PAIRS     = (ROW_BYTES + 1) / 2;
  localparam int DEPTH     = PAIRS * PANEL_HEIGHT;
  localparam int AW        = $clog2(DEPTH);

  cfg_t              cfg;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;
  logic [OUT_CW-1:0] fifo_count;
  logic              push;
  beat_t             push_beat;

  mlcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlcd_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mlcd_seq #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .DEPTH        (DEPTH),
    .AW           (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_column  (in_column),
    .in_row     (in_row),
    .in_colour  (in_colour),
    .in_flag    (in_flag),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .fifo_count (fifo_count),
    .push       (push),
    .push_beat  (push_beat)
  );

  mlcd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .count     (fifo_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for memory_lcd_frame_line_sender_core: directed and random items,
// with a frame store shadow and command framer predictor. Depends on mlcd_pkg and the core.
module testbench;
  import mlcd_pkg::*;

  localparam int PANEL_W     = 176;
  localparam int PANEL_H     = 176;
  localparam int ROW_BYTES   = (PANEL_W + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 16;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_mode = MODE_DRAW;
  logic [8:0]          in_column = '0;
  logic [8:0]          in_row = '0;
  logic [3:0]          in_colour = '0;
  logic                in_flag = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [15:0]         out_word;
  logic                out_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Shadow of the block: frame store, polarity flag and registers
  logic [7:0]          fb_shadow [0:STORE_BYTES-1];
  logic                vcom_shadow;
  cfg_t                cfg_shadow;
  beat_t               beats_due [$];

  int                  mismatches = 0;
  int                  cycles = 0;
  int                  tx_idle_pct = 0;
  int                  rx_stall_pct = 0;
  int                  rx_hold_left = 0;

  memory_lcd_frame_line_sender_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_column(in_column),
    .in_row   (in_row),
    .in_colour(in_colour),
    .in_flag  (in_flag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .out_last (out_last),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Receiver: hold off for a counted stretch when asked, else stall at random
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare each output beat with the oldest expected beat
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat word=%h last=%b", out_word, out_last));
      end else begin
        want = beats_due.pop_front();
        if (out_word !== want.word)
          report_mismatch($sformatf("word %h, expected %h", out_word, want.word));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
      end
    end
  end

  task automatic reset_shadow;
    cfg_shadow.update_command    = RST_UPDATE;
    cfg_shadow.vcom_mask         = RST_VCOM_MASK;
    cfg_shadow.all_clear_command = RST_ALL_CLEAR;
    cfg_shadow.inversion_command = RST_INVERSION;
    cfg_shadow.no_update_command = RST_NO_UPDATE;
    cfg_shadow.background_colour = RST_BACKGROUND;
    vcom_shadow = 1'b1;
    for (int i = 0; i < STORE_BYTES; i++)
      fb_shadow[i] = {cfg_shadow.background_colour, cfg_shadow.background_colour};
  endtask

  function automatic logic [7:0] command_byte(input logic [7:0] cmd);
    return cmd | (vcom_shadow ? cfg_shadow.vcom_mask : 8'h00);
  endfunction

  // Apply one accepted item to the shadow and queue the beats it yields
  task automatic predict_beats(input logic [1:0] mode, input logic [8:0] column,
                               input logic [8:0] row, input logic [3:0] colour,
                               input logic flag);
    logic [7:0] bytes [$];
    beat_t      b;
    int         idx;
    int         nwords;
    case (mode)
      MODE_DRAW: begin
        if (column < PANEL_W && row < PANEL_H) begin
          idx = row * ROW_BYTES + column / 2;
          if (column[0] == 1'b0)
            fb_shadow[idx] = {colour, fb_shadow[idx][3:0]};
          else
            fb_shadow[idx] = {fb_shadow[idx][7:4], colour};
        end
      end
      MODE_LINE: begin
        if (row < PANEL_H) begin
          bytes.push_back(command_byte(cfg_shadow.update_command));
          vcom_shadow = ~vcom_shadow;
          bytes.push_back(8'(row + 1));
          for (int k = 0; k < ROW_BYTES; k++)
            bytes.push_back(fb_shadow[row * ROW_BYTES + k]);
          bytes.push_back(8'h00);
          bytes.push_back(8'h00);
          // pad an odd byte count with a zero low byte
          if (bytes.size() % 2)
            bytes.push_back(8'h00);
          nwords = bytes.size() / 2;
          for (int k = 0; k < nwords; k++) begin
            b.word = {bytes[2*k], bytes[2*k+1]};
            b.last = (k == nwords - 1);
            beats_due.push_back(b);
          end
        end
      end
      default: begin
        if (mode == MODE_CLEAR)
          b.word = {command_byte(flag ? cfg_shadow.all_clear_command
                                      : cfg_shadow.no_update_command), 8'h00};
        else
          b.word = {command_byte(flag ? cfg_shadow.inversion_command
                                      : cfg_shadow.no_update_command), 8'h00};
        b.last = 1'b1;
        vcom_shadow = ~vcom_shadow;
        beats_due.push_back(b);
      end
    endcase
  endtask

  // Offer one item, idling first at random, and predict it once accepted
  task automatic send_item(input logic [1:0] mode, input logic [8:0] column,
                           input logic [8:0] row, input logic [3:0] colour,
                           input logic flag);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_column <= column;
    in_row    <= row;
    in_colour <= colour;
    in_flag   <= flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beats(mode, column, row, colour, flag);
  endtask

  // Wait until every expected beat is out and a pending draw has settled
  task automatic drain;
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup, then access until pready, then back to idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_UPDATE:     cfg_shadow.update_command    = value[7:0];
      REG_VCOM_MASK:  cfg_shadow.vcom_mask         = value[7:0];
      REG_ALL_CLEAR:  cfg_shadow.all_clear_command = value[7:0];
      REG_INVERSION:  cfg_shadow.inversion_command = value[7:0];
      REG_NO_UPDATE:  cfg_shadow.no_update_command = value[7:0];
      REG_BACKGROUND: cfg_shadow.background_colour = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [7:0] cmd_val, input logic [3:0] bg_val);
    write_reg(REG_UPDATE, {24'h0, cmd_val});
    write_reg(REG_VCOM_MASK, {24'h0, cmd_val});
    write_reg(REG_ALL_CLEAR, {24'h0, cmd_val});
    write_reg(REG_INVERSION, {24'h0, cmd_val});
    write_reg(REG_NO_UPDATE, {24'h0, cmd_val});
    write_reg(REG_BACKGROUND, {28'h0, bg_val});
  endtask

  // Reset values: background fill, polarity start and each command
  task automatic test_reset_state;
    send_item(MODE_LINE, 9'd0, 9'd0, 4'd0, 1'b0);
    send_item(MODE_LINE, 9'd0, 9'(PANEL_H - 1), 4'd0, 1'b0);
    send_item(MODE_CLEAR, 9'd0, 9'd0, 4'd0, 1'b1);
    send_item(MODE_CLEAR, 9'd0, 9'd0, 4'd0, 1'b0);
    send_item(MODE_INVERT, 9'd0, 9'd0, 4'd0, 1'b1);
    send_item(MODE_INVERT, 9'd0, 9'd0, 4'd0, 1'b0);
    drain();
  endtask

  // Corner pixels, both nibbles, and coordinates off the panel
  task automatic test_draw_edges;
    send_item(MODE_DRAW, 9'd0, 9'd0, 4'hF, 1'b0);
    send_item(MODE_DRAW, 9'd1, 9'd0, 4'hA, 1'b1);
    send_item(MODE_DRAW, 9'(PANEL_W - 1), 9'(PANEL_H - 1), 4'hF, 1'b0);
    send_item(MODE_DRAW, 9'(PANEL_W - 2), 9'(PANEL_H - 1), 4'h5, 1'b0);
    send_item(MODE_DRAW, 9'(PANEL_W), 9'd0, 4'hF, 1'b0);
    send_item(MODE_DRAW, 9'd0, 9'(PANEL_H), 4'hF, 1'b0);
    send_item(MODE_DRAW, 9'h1FF, 9'h1FF, 4'hF, 1'b1);
    send_item(MODE_LINE, 9'd0, 9'(PANEL_H), 4'd0, 1'b0);
    send_item(MODE_LINE, 9'h1FF, 9'h1FF, 4'hF, 1'b1);
    send_item(MODE_LINE, 9'd0, 9'd0, 4'd0, 1'b0);
    send_item(MODE_LINE, 9'd0, 9'(PANEL_H - 1), 4'd0, 1'b0);
    drain();
  endtask

  // All registers at their extremes; a new background must not refill the store
  task automatic test_register_extremes;
    write_all_regs(8'hFF, 4'hF);
    send_item(MODE_LINE, 9'd0, 9'd3, 4'd0, 1'b0);
    send_item(MODE_CLEAR, 9'd0, 9'd0, 4'd0, 1'b1);
    send_item(MODE_INVERT, 9'd0, 9'd0, 4'd0, 1'b0);
    drain();
    write_all_regs(8'h00, 4'h0);
    send_item(MODE_LINE, 9'd0, 9'd3, 4'd0, 1'b0);
    send_item(MODE_INVERT, 9'd0, 9'd0, 4'd0, 1'b1);
    drain();
  endtask

  // Long receiver hold-off while lines keep coming, then a full drain
  task automatic test_output_backpressure;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 600;
    for (int i = 0; i < 10; i++)
      send_item(MODE_LINE, 9'd0, 9'(i), 4'd0, 1'b0);
    drain();
  endtask

  task automatic send_random;
    int         pick;
    logic [1:0] m;
    logic [8:0] c;
    logic [8:0] r;
    logic [3:0] k;
    logic       f;
    pick = $urandom_range(99);
    k = 4'($urandom);
    f = 1'($urandom);
    c = 9'($urandom_range(PANEL_W - 1));
    // favor a few rows so that lines read back what draws left
    r = $urandom_range(1) ? 9'($urandom_range(7)) : 9'($urandom_range(PANEL_H - 1));
    if (pick < 50)      m = MODE_DRAW;
    else if (pick < 75) m = MODE_LINE;
    else if (pick < 82) m = MODE_CLEAR;
    else if (pick < 89) m = MODE_INVERT;
    else begin
      m = $urandom_range(1) ? MODE_LINE : MODE_DRAW;
      c = 9'($urandom);
      r = 9'($urandom);
    end
    send_item(m, c, r, k, f);
  endtask

  // Random traffic under one idling profile and fresh register values
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    write_reg(REG_UPDATE, $urandom);
    write_reg(REG_VCOM_MASK, $urandom);
    write_reg(REG_ALL_CLEAR, $urandom);
    write_reg(REG_INVERSION, $urandom);
    write_reg(REG_NO_UPDATE, $urandom);
    write_reg(REG_BACKGROUND, $urandom);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < count; i++)
      send_random();
    drain();
  endtask

  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_draw_edges();
    test_register_extremes();
    test_output_backpressure();
    test_random_phase(0, 0, 50);
    test_random_phase(75, 0, 50);
    test_random_phase(0, 75, 50);
    test_random_phase(22, 22, 50);
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mlcd_pkg.sv
hdl/mlcd_cfg_regs.sv
hdl/mlcd_frame_ram.sv
hdl/mlcd_out_fifo.sv
hdl/mlcd_seq.sv
hdl/memory_lcd_frame_line_sender_core.sv
verif/testbench.sv
